// ----- design/lpmd_pkg.sv -----
// Shared types and constants for the length-prefixed message deframer.
package lpmd_pkg;

   localparam int unsigned QueueDepth = 4;
   localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
   localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

   localparam logic [16:0] MAX_LEN_RESET = 17'd4096;

   typedef enum logic [3:0] {
      PH_LEN     = 4'd0,
      PH_IP      = 4'd1,
      PH_PORT    = 4'd2,
      PH_TLEN    = 4'd3,
      PH_TOPIC   = 4'd4,
      PH_TYPE    = 4'd5,
      PH_CLEN    = 4'd6,
      PH_CONTENT = 4'd7,
      PH_SKIP    = 4'd8
   } phase_type;

   localparam logic [1:0] KIND_TOPIC   = 2'd0;
   localparam logic [1:0] KIND_CONTENT = 2'd1;
   localparam logic [1:0] KIND_SUMMARY = 2'd2;
   localparam logic [1:0] KIND_LEN_ERR = 2'd3;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_HDR_CUT    = 3'd1;
   localparam logic [2:0] ST_TOPIC_OVR  = 3'd2;
   localparam logic [2:0] ST_CONT_OVR   = 3'd3;
   localparam logic [2:0] ST_CONT_SHORT = 3'd4;
   localparam logic [2:0] ST_BAD_SIGN   = 3'd5;
   localparam logic [2:0] ST_BAD_TYPE   = 3'd6;

   localparam logic [7:0] TYPE_INT    = 8'd0;
   localparam logic [7:0] TYPE_SREAL  = 8'd1;
   localparam logic [7:0] TYPE_FLOAT  = 8'd2;
   localparam logic [7:0] TYPE_STRING = 8'd3;
   localparam logic [7:0] TYPE_NONE   = 8'd255;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data_byte;
      logic [31:0] src_addr;
      logic [15:0] src_port;
      logic [7:0]  topic_length;
      logic [7:0]  data_type;
      logic [15:0] content_length;
      logic [2:0]  status;
      logic        value_negative;
      logic [31:0] value_magnitude;
      logic [7:0]  decimal_power;
      logic        last;
   } result_type;

endpackage

// ----- design/length_prefixed_message_deframer_core.sv -----
// Length-prefixed message deframer: byte parser, result queue and limit register.
// A request accepted into the input register is parsed once the result queue has room for
//    two results; its results are then written into the queue and offered on rsp_.
// Throughput: one byte per cycle while the result queue has room for two results; a
//    byte that yields two (final content byte plus summary) needs two queue slots.
// Reset (synchronous, active high) empties the input stage and result queue, sets
//    the parser to await a length prefix and the payload limit to 4096.
module length_prefixed_message_deframer_core (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_stream_byte,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_data_byte,
   output logic [31:0] rsp_src_addr,
   output logic [15:0] rsp_src_port,
   output logic [7:0]  rsp_topic_length,
   output logic [7:0]  rsp_data_type,
   output logic [15:0] rsp_content_length,
   output logic [2:0]  rsp_status,
   output logic        rsp_value_negative,
   output logic [31:0] rsp_value_magnitude,
   output logic [7:0]  rsp_decimal_power,
   output logic        rsp_last,
   // configuration
   input  logic        csr_wr_en,
   input  logic [16:0] csr_max_payload_len
);
   import lpmd_pkg::*;

   // ---------------------------------------------------------------------------
   // Input register: holds one request until the parser has room for its results.
   // ---------------------------------------------------------------------------
   logic        in_vld_ff, in_vld_in;
   logic [7:0]  in_byte_ff;
   logic        req_accept;
   logic        fire;

   // ---------------------------------------------------------------------------
   // Parser state
   // ---------------------------------------------------------------------------
   phase_type   phase_ff, phase_in;
   logic [2:0]  byte_idx_ff, byte_idx_in;
   logic [31:0] shift_ff, shift_in;
   logic [16:0] pay_left_ff, pay_left_in;
   logic [15:0] field_left_ff, field_left_in;
   logic [31:0] ip_ff, ip_in;
   logic [15:0] port_ff, port_in;
   logic [7:0]  tlen_ff, tlen_in;
   logic [7:0]  type_ff, type_in;
   logic [15:0] clen_ff, clen_in;
   logic [47:0] cap_ff, cap_in;
   logic [2:0]  err_ff, err_in;
   logic [16:0] max_len_ff;

   // ---------------------------------------------------------------------------
   // Result queue
   // ---------------------------------------------------------------------------
   result_type           q_ff [QueueDepth];
   logic [QueuePtrW-1:0] head_ff, tail_ff;
   logic [QueueCntW-1:0] cnt_ff;
   logic [1:0]           push_n;
   logic                 pop;
   result_type           res0, res1;

   // Parser working values
   logic [7:0]  b;
   logic [31:0] shift_nx;
   logic [2:0]  idx_nx;
   logic [15:0] cap_k;
   logic [7:0]  sign_b;
   result_type  summ;

   assign b          = in_byte_ff;
   // Room for two results is checked on the count alone, so rsp_stall never
   // reaches req_stall in the same cycle.
   assign fire       = in_vld_ff && (cnt_ff <= QueueCntW'(QueueDepth - 2));
   assign req_stall  = in_vld_ff && !fire;
   assign req_accept = req_valid && !req_stall;
   assign in_vld_in  = req_accept || (in_vld_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
      if (req_accept) begin
         in_byte_ff <= req_stream_byte;
      end
   end

   // Payload limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_LEN_RESET;
      end else if (csr_wr_en) begin
         max_len_ff <= csr_max_payload_len;
      end
   end

   // ---------------------------------------------------------------------------
   // One byte of parsing: next state plus up to two results.
   // ---------------------------------------------------------------------------
   always_comb begin
      phase_in      = phase_ff;
      byte_idx_in   = byte_idx_ff;
      shift_in      = shift_ff;
      pay_left_in   = pay_left_ff;
      field_left_in = field_left_ff;
      ip_in         = ip_ff;
      port_in       = port_ff;
      tlen_in       = tlen_ff;
      type_in       = type_ff;
      clen_in       = clen_ff;
      cap_in        = cap_ff;
      err_in        = err_ff;
      push_n        = 2'd0;
      res0          = '0;
      res1          = '0;
      summ          = '0;
      sign_b        = 8'd0;

      shift_nx = {shift_ff[23:0], b};
      idx_nx   = byte_idx_ff + 3'd1;
      cap_k    = clen_ff - field_left_ff;

      if (phase_ff == PH_LEN) begin
         // Gather the four prefix bytes, then check the length against the limit.
         shift_in    = shift_nx;
         byte_idx_in = idx_nx;
         if (idx_nx >= 3'd4) begin
            byte_idx_in   = 3'd0;
            shift_in      = '0;
            field_left_in = '0;
            ip_in         = '0;
            port_in       = '0;
            tlen_in       = '0;
            type_in       = TYPE_NONE;
            clen_in       = '0;
            cap_in        = '0;
            err_in        = ST_OK;
            if (shift_nx == 32'd0 || shift_nx > {15'd0, max_len_ff}) begin
               res0.kind = KIND_LEN_ERR;
               res0.last = 1'b1;
               push_n    = 2'd1;
            end else begin
               pay_left_in = shift_nx[16:0];
               phase_in    = PH_IP;
            end
         end
      end else begin
         if (pay_left_ff != 17'd0) begin
            pay_left_in = pay_left_ff - 17'd1;
         end

         unique case (phase_ff)
            PH_IP: begin
               shift_in    = shift_nx;
               byte_idx_in = idx_nx;
               if (idx_nx >= 3'd4) begin
                  ip_in       = shift_nx;
                  shift_in    = '0;
                  byte_idx_in = 3'd0;
                  phase_in    = PH_PORT;
               end
            end
            PH_PORT: begin
               shift_in    = shift_nx;
               byte_idx_in = idx_nx;
               if (idx_nx >= 3'd2) begin
                  port_in     = shift_nx[15:0];
                  shift_in    = '0;
                  byte_idx_in = 3'd0;
                  phase_in    = PH_TLEN;
               end
            end
            PH_TLEN: begin
               tlen_in = b;
               if ({9'd0, b} > pay_left_in) begin
                  err_in   = ST_TOPIC_OVR;
                  phase_in = PH_SKIP;
               end else if (b == 8'd0) begin
                  phase_in = PH_TYPE;
               end else begin
                  field_left_in = {8'd0, b};
                  phase_in      = PH_TOPIC;
               end
            end
            PH_TOPIC: begin
               res0.kind      = KIND_TOPIC;
               res0.data_byte = b;
               res0.last      = 1'b1;
               push_n         = 2'd1;
               if (field_left_ff != 16'd0) begin
                  field_left_in = field_left_ff - 16'd1;
               end
               if (field_left_in == 16'd0) begin
                  phase_in = PH_TYPE;
               end
            end
            PH_TYPE: begin
               type_in  = b;
               phase_in = PH_CLEN;
            end
            PH_CLEN: begin
               shift_in    = shift_nx;
               byte_idx_in = idx_nx;
               if (idx_nx >= 3'd2) begin
                  clen_in     = shift_nx[15:0];
                  shift_in    = '0;
                  byte_idx_in = 3'd0;
                  if ({1'b0, shift_nx[15:0]} > pay_left_in) begin
                     err_in   = ST_CONT_OVR;
                     phase_in = PH_SKIP;
                  end else begin
                     field_left_in = shift_nx[15:0];
                     phase_in = (shift_nx[15:0] != 16'd0) ? PH_CONTENT : PH_SKIP;
                  end
               end
            end
            PH_CONTENT: begin
               res0.kind      = KIND_CONTENT;
               res0.data_byte = b;
               res0.last      = 1'b1;
               push_n         = 2'd1;
               // Capture the first six content bytes, first byte in the top lane.
               if (cap_k < 16'd6) begin
                  case (cap_k[2:0])
                     3'd0:    cap_in[47:40] = cap_ff[47:40] | b;
                     3'd1:    cap_in[39:32] = cap_ff[39:32] | b;
                     3'd2:    cap_in[31:24] = cap_ff[31:24] | b;
                     3'd3:    cap_in[23:16] = cap_ff[23:16] | b;
                     3'd4:    cap_in[15:8]  = cap_ff[15:8]  | b;
                     default: cap_in[7:0]   = cap_ff[7:0]   | b;
                  endcase
               end
               if (field_left_ff != 16'd0) begin
                  field_left_in = field_left_ff - 16'd1;
               end
               if (field_left_in == 16'd0) begin
                  phase_in = PH_SKIP;
               end
            end
            default: begin
               // trailing payload bytes: drop
            end
         endcase

         if (pay_left_in == 17'd0) begin
            // Last payload byte: build the summary from the updated packet state.
            summ.kind           = KIND_SUMMARY;
            summ.last           = 1'b1;
            summ.src_addr       = ip_in;
            summ.src_port       = port_in;
            summ.topic_length   = tlen_in;
            summ.data_type      = type_in;
            summ.content_length = clen_in;
            sign_b              = cap_in[47:40];
            if (err_in != ST_OK) begin
               summ.status = err_in;
            end else if (phase_in >= PH_IP && phase_in <= PH_CLEN) begin
               summ.status = ST_HDR_CUT;
            end else if (type_in == TYPE_INT || type_in == TYPE_FLOAT) begin
               if (clen_in < ((type_in == TYPE_INT) ? 16'd5 : 16'd6)) begin
                  summ.status = ST_CONT_SHORT;
               end else if (sign_b > 8'd1) begin
                  summ.status = ST_BAD_SIGN;
               end else begin
                  summ.value_negative  = sign_b[0];
                  summ.value_magnitude = cap_in[39:8];
                  summ.decimal_power   = (type_in == TYPE_FLOAT) ? cap_in[7:0] : 8'd0;
               end
            end else if (type_in == TYPE_SREAL) begin
               if (clen_in < 16'd2) begin
                  summ.status = ST_CONT_SHORT;
               end else begin
                  summ.value_magnitude = {16'd0, cap_in[47:32]};
                  summ.decimal_power   = 8'd2;
               end
            end else if (type_in != TYPE_STRING) begin
               summ.status = ST_BAD_TYPE;
            end

            if (push_n == 2'd1) begin
               res0.last = 1'b0;
               res1      = summ;
               push_n    = 2'd2;
            end else begin
               res0   = summ;
               push_n = 2'd1;
            end

            phase_in      = PH_LEN;
            byte_idx_in   = 3'd0;
            shift_in      = '0;
            field_left_in = '0;
            ip_in         = '0;
            port_in       = '0;
            tlen_in       = '0;
            type_in       = TYPE_NONE;
            clen_in       = '0;
            cap_in        = '0;
            err_in        = ST_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_LEN;
         byte_idx_ff   <= '0;
         shift_ff      <= '0;
         pay_left_ff   <= '0;
         field_left_ff <= '0;
         ip_ff         <= '0;
         port_ff       <= '0;
         tlen_ff       <= '0;
         type_ff       <= TYPE_NONE;
         clen_ff       <= '0;
         cap_ff        <= '0;
         err_ff        <= ST_OK;
      end else if (fire) begin
         phase_ff      <= phase_in;
         byte_idx_ff   <= byte_idx_in;
         shift_ff      <= shift_in;
         pay_left_ff   <= pay_left_in;
         field_left_ff <= field_left_in;
         ip_ff         <= ip_in;
         port_ff       <= port_in;
         tlen_ff       <= tlen_in;
         type_ff       <= type_in;
         clen_ff       <= clen_in;
         cap_ff        <= cap_in;
         err_ff        <= err_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Result queue: two writes, one read per cycle.
   // ---------------------------------------------------------------------------
   logic [1:0]           push_eff;
   logic [QueuePtrW-1:0] tail_p1;

   assign pop      = rsp_valid && !rsp_stall;
   assign push_eff = fire ? push_n : 2'd0;
   assign tail_p1  = tail_ff + QueuePtrW'(1);

   always_ff @(posedge clock) begin
      for (int i = 0; i < QueueDepth; i++) begin
         if (push_eff != 2'd0 && tail_ff == QueuePtrW'(i)) begin
            q_ff[i] <= res0;
         end
         if (push_eff == 2'd2 && tail_p1 == QueuePtrW'(i)) begin
            q_ff[i] <= res1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         if (pop) begin
            head_ff <= head_ff + QueuePtrW'(1);
         end
         tail_ff <= tail_ff + QueuePtrW'(push_eff);
         cnt_ff  <= cnt_ff + QueueCntW'(push_eff) - QueueCntW'(pop);
      end
   end

   assign rsp_valid           = (cnt_ff != '0);
   assign rsp_kind            = q_ff[head_ff].kind;
   assign rsp_data_byte       = q_ff[head_ff].data_byte;
   assign rsp_src_addr        = q_ff[head_ff].src_addr;
   assign rsp_src_port        = q_ff[head_ff].src_port;
   assign rsp_topic_length    = q_ff[head_ff].topic_length;
   assign rsp_data_type       = q_ff[head_ff].data_type;
   assign rsp_content_length  = q_ff[head_ff].content_length;
   assign rsp_status          = q_ff[head_ff].status;
   assign rsp_value_negative  = q_ff[head_ff].value_negative;
   assign rsp_value_magnitude = q_ff[head_ff].value_magnitude;
   assign rsp_decimal_power   = q_ff[head_ff].decimal_power;
   assign rsp_last            = q_ff[head_ff].last;

`ifndef SYNTHESIS
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QueueCntW'(QueueDepth))
      else $error("result queue count exceeds depth");

   a_payload_live: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_LEN |-> pay_left_ff != 17'd0)
      else $error("inside a payload with no bytes left");

   a_field_live: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_TOPIC || phase_ff == PH_CONTENT) |-> field_left_ff != 16'd0)
      else $error("topic or content phase with empty field");

   a_no_stall_empty: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> cnt_ff > QueueCntW'(QueueDepth - 2))
      else $error("request stalled while queue has room");
`endif

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the length-prefixed message deframer core.
module tb;
   import lpmd_pkg::*;

   localparam int unsigned HALF_PERIOD   = 6;
   localparam int unsigned RESET_CYCLES  = 11;
   localparam int unsigned SETTLE_CYCLES = 10;       // pipeline: input register, then result queue
   localparam int unsigned TIMEOUT_NS    = 3_600_000;
   localparam int unsigned RANDOM_BYTES  = 50;       // per idling regime

   // shortest content that still carries a whole value
   localparam logic [15:0] INT_MIN_BYTES   = 16'd5;
   localparam logic [15:0] SREAL_MIN_BYTES = 16'd2;
   localparam logic [15:0] FLOAT_MIN_BYTES = 16'd6;
   localparam logic [7:0]  SREAL_POWER     = 8'd2;

   localparam logic [16:0] LIMIT_MAX = 17'h1_FFFF;

   logic        clock;
   logic        reset               = 1'b1;
   logic        req_valid           = 1'b0;
   logic        req_stall;
   logic [7:0]  req_stream_byte     = 8'd0;
   logic        rsp_valid;
   logic        rsp_stall           = 1'b0;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_data_byte;
   logic [31:0] rsp_src_addr;
   logic [15:0] rsp_src_port;
   logic [7:0]  rsp_topic_length;
   logic [7:0]  rsp_data_type;
   logic [15:0] rsp_content_length;
   logic [2:0]  rsp_status;
   logic        rsp_value_negative;
   logic [31:0] rsp_value_magnitude;
   logic [7:0]  rsp_decimal_power;
   logic        rsp_last;
   logic        csr_wr_en           = 1'b0;
   logic [16:0] csr_max_payload_len = MAX_LEN_RESET;

   length_prefixed_message_deframer_core u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_stream_byte     (req_stream_byte),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_kind            (rsp_kind),
      .rsp_data_byte       (rsp_data_byte),
      .rsp_src_addr        (rsp_src_addr),
      .rsp_src_port        (rsp_src_port),
      .rsp_topic_length    (rsp_topic_length),
      .rsp_data_type       (rsp_data_type),
      .rsp_content_length  (rsp_content_length),
      .rsp_status          (rsp_status),
      .rsp_value_negative  (rsp_value_negative),
      .rsp_value_magnitude (rsp_value_magnitude),
      .rsp_decimal_power   (rsp_decimal_power),
      .rsp_last            (rsp_last),
      .csr_wr_en           (csr_wr_en),
      .csr_max_payload_len (csr_max_payload_len)
   );

   // Bytes still to be offered on the request channel, and the records the
   // block owes us, oldest first.
   logic [7:0] stream_backlog[$];
   result_type expected_records[$];
   logic [7:0] frame_body[$];    // payload under construction

   int unsigned send_idle_pct  = 0;
   int unsigned recv_idle_pct  = 0;
   int unsigned mismatch_count = 0;
   int unsigned records_checked = 0;
   int unsigned bytes_planned  = 0;

   // Shadow of the parser: limit register plus per-packet state.
   logic [16:0] max_len;
   phase_type   ph;
   int unsigned byte_idx;
   logic [31:0] shift_acc;
   logic [16:0] pay_left;
   logic [15:0] fld_left;
   logic [31:0] ip_q;
   logic [15:0] port_q;
   logic [7:0]  tlen_q;
   logic [7:0]  dtype_q;
   logic [15:0] clen_q;
   logic [47:0] capture_q;
   logic [2:0]  err_q;

   result_type observed;
   assign observed = {rsp_kind, rsp_data_byte, rsp_src_addr, rsp_src_port,
                      rsp_topic_length, rsp_data_type, rsp_content_length, rsp_status,
                      rsp_value_negative, rsp_value_magnitude, rsp_decimal_power, rsp_last};

   initial begin
      clock = 1'b0;
      forever #HALF_PERIOD clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------

   // Drop everything a packet left behind; the stream position survives.
   task automatic clear_packet();
      byte_idx  = 0;
      shift_acc = '0;
      fld_left  = '0;
      ip_q      = '0;
      port_q    = '0;
      tlen_q    = '0;
      dtype_q   = TYPE_NONE;
      clen_q    = '0;
      capture_q = '0;
      err_q     = ST_OK;
   endtask

   function automatic result_type blank_record(input logic [1:0] kind);
      result_type rec;
      rec      = '0;
      rec.kind = kind;
      return rec;
   endfunction

   // Closing record of a packet: header fields plus the decoded value.
   function automatic result_type summary_record();
      result_type rec;
      logic [7:0] sign;
      rec = blank_record(KIND_SUMMARY);
      sign = capture_q[47:40];
      if (err_q != ST_OK) begin
         rec.status = err_q;
      end else if (ph >= PH_IP && ph <= PH_CLEN) begin
         rec.status = ST_HDR_CUT;
      end else if (dtype_q == TYPE_INT || dtype_q == TYPE_FLOAT) begin
         // length is judged before the sign byte
         if (clen_q < ((dtype_q == TYPE_INT) ? INT_MIN_BYTES : FLOAT_MIN_BYTES)) begin
            rec.status = ST_CONT_SHORT;
         end else if (sign > 8'd1) begin
            rec.status = ST_BAD_SIGN;
         end else begin
            rec.value_negative  = sign[0];
            rec.value_magnitude = capture_q[39:8];
            rec.decimal_power   = (dtype_q == TYPE_FLOAT) ? capture_q[7:0] : 8'd0;
         end
      end else if (dtype_q == TYPE_SREAL) begin
         if (clen_q < SREAL_MIN_BYTES) begin
            rec.status = ST_CONT_SHORT;
         end else begin
            rec.value_magnitude = {16'd0, capture_q[47:32]};
            rec.decimal_power   = SREAL_POWER;
         end
      end else if (dtype_q != TYPE_STRING) begin
         rec.status = ST_BAD_TYPE;
      end
      rec.src_addr       = ip_q;
      rec.src_port       = port_q;
      rec.topic_length   = tlen_q;
      rec.data_type      = dtype_q;
      rec.content_length = clen_q;
      return rec;
   endfunction

   // Advance the shadow parser by one accepted byte and queue what it yields.
   task automatic parse_stream_byte(input logic [7:0] b);
      result_type  recs[2];
      int unsigned n;
      int unsigned k;
      logic [31:0] len;
      n = 0;
      if (ph == PH_LEN) begin
         shift_acc = {shift_acc[23:0], b};
         byte_idx++;
         if (byte_idx >= 4) begin
            len = shift_acc;
            clear_packet();
            if (len == 0 || len > {15'd0, max_len}) begin
               recs[0] = blank_record(KIND_LEN_ERR);
               n = 1;
            end else begin
               pay_left = len[16:0];
               ph = PH_IP;
            end
         end
      end else begin
         if (pay_left > 0) pay_left--;
         case (ph)
            PH_IP: begin
               shift_acc = {shift_acc[23:0], b};
               byte_idx++;
               if (byte_idx >= 4) begin
                  ip_q = shift_acc;
                  shift_acc = '0;
                  byte_idx = 0;
                  ph = PH_PORT;
               end
            end
            PH_PORT: begin
               shift_acc = {shift_acc[23:0], b};
               byte_idx++;
               if (byte_idx >= 2) begin
                  port_q = shift_acc[15:0];
                  shift_acc = '0;
                  byte_idx = 0;
                  ph = PH_TLEN;
               end
            end
            PH_TLEN: begin
               tlen_q = b;
               if ({9'd0, b} > pay_left) begin
                  err_q = ST_TOPIC_OVR;
                  ph = PH_SKIP;
               end else if (b == 8'd0) begin
                  ph = PH_TYPE;
               end else begin
                  fld_left = {8'd0, b};
                  ph = PH_TOPIC;
               end
            end
            PH_TOPIC: begin
               recs[n] = blank_record(KIND_TOPIC);
               recs[n].data_byte = b;
               n++;
               if (fld_left > 0) fld_left--;
               if (fld_left == 0) ph = PH_TYPE;
            end
            PH_TYPE: begin
               dtype_q = b;
               ph = PH_CLEN;
            end
            PH_CLEN: begin
               shift_acc = {shift_acc[23:0], b};
               byte_idx++;
               if (byte_idx >= 2) begin
                  clen_q = shift_acc[15:0];
                  shift_acc = '0;
                  byte_idx = 0;
                  if ({1'b0, clen_q} > pay_left) begin
                     err_q = ST_CONT_OVR;
                     ph = PH_SKIP;
                  end else begin
                     fld_left = clen_q;
                     ph = (fld_left > 0) ? PH_CONTENT : PH_SKIP;
                  end
               end
            end
            PH_CONTENT: begin
               k = 32'(clen_q - fld_left);
               recs[n] = blank_record(KIND_CONTENT);
               recs[n].data_byte = b;
               n++;
               // keep the first six content bytes, first byte uppermost
               if (k < 6) capture_q[8*(5-k) +: 8] = capture_q[8*(5-k) +: 8] | b;
               if (fld_left > 0) fld_left--;
               if (fld_left == 0) ph = PH_SKIP;
            end
            default: begin
            end
         endcase
         if (pay_left == 0) begin
            recs[n] = summary_record();
            n++;
            ph = PH_LEN;
            clear_packet();
         end
      end
      for (int i = 0; i < n; i++) begin
         recs[i].last = (i == n - 1);
         expected_records.push_back(recs[i]);
      end
   endtask

   // ------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------

   task automatic note_mismatch(input string what, input logic [31:0] got_v,
                                input logic [31:0] want_v);
      mismatch_count++;
      $display("mismatch at %0t, result %0d, %s: got 0x%0h, want 0x%0h",
               $realtime, records_checked, what, got_v, want_v);
   endtask

   task automatic check_record(input result_type got, input result_type want);
      if (got.kind !== want.kind)
         note_mismatch("kind", 32'(got.kind), 32'(want.kind));
      if (got.data_byte !== want.data_byte)
         note_mismatch("data_byte", 32'(got.data_byte), 32'(want.data_byte));
      if (got.src_addr !== want.src_addr)
         note_mismatch("src_addr", got.src_addr, want.src_addr);
      if (got.src_port !== want.src_port)
         note_mismatch("src_port", 32'(got.src_port), 32'(want.src_port));
      if (got.topic_length !== want.topic_length)
         note_mismatch("topic_length", 32'(got.topic_length), 32'(want.topic_length));
      if (got.data_type !== want.data_type)
         note_mismatch("data_type", 32'(got.data_type), 32'(want.data_type));
      if (got.content_length !== want.content_length)
         note_mismatch("content_length", 32'(got.content_length),
                       32'(want.content_length));
      if (got.status !== want.status)
         note_mismatch("status", 32'(got.status), 32'(want.status));
      if (got.value_negative !== want.value_negative)
         note_mismatch("value_negative", 32'(got.value_negative),
                       32'(want.value_negative));
      if (got.value_magnitude !== want.value_magnitude)
         note_mismatch("value_magnitude", got.value_magnitude, want.value_magnitude);
      if (got.decimal_power !== want.decimal_power)
         note_mismatch("decimal_power", 32'(got.decimal_power), 32'(want.decimal_power));
      if (got.last !== want.last)
         note_mismatch("last", 32'(got.last), 32'(want.last));
      records_checked++;
   endtask

   // ------------------------------------------------------------------
   // Driver: offer the backlog one byte at a time, predicting on acceptance.
   // A stalled request holds both valid and payload.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            parse_stream_byte(req_stream_byte);
            void'(stream_backlog.pop_front());
         end
         if (req_valid && req_stall) begin
            // hold the stalled request as it is
         end else if (stream_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid       <= 1'b1;
            req_stream_byte <= stream_backlog[0];
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: compare each accepted result with the oldest expectation,
   // then pick the stall for the next cycle.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid === 1'b1 && !rsp_stall) begin
            if (expected_records.size() == 0)
               note_mismatch("result with nothing expected, kind", 32'(observed.kind),
                             32'd0);
            else
               check_record(observed, expected_records.pop_front());
         end
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   task automatic send_prefix(input logic [31:0] len);
      stream_backlog.push_back(len[31:24]);
      stream_backlog.push_back(len[23:16]);
      stream_backlog.push_back(len[15:8]);
      stream_backlog.push_back(len[7:0]);
      bytes_planned += 4;
   endtask

   task automatic add_random(input int n);
      logic [7:0] v;
      for (int i = 0; i < n; i++) begin
         v = 8'($urandom);
         frame_body.push_back(v);
      end
   endtask

   // Start a payload: address, port, topic length and random topic bytes.
   task automatic open_frame(input logic [31:0] ip, input logic [15:0] port,
                             input logic [7:0] tlen);
      frame_body.delete();
      frame_body.push_back(ip[31:24]);
      frame_body.push_back(ip[23:16]);
      frame_body.push_back(ip[15:8]);
      frame_body.push_back(ip[7:0]);
      frame_body.push_back(port[15:8]);
      frame_body.push_back(port[7:0]);
      frame_body.push_back(tlen);
      add_random(int'(tlen));
   endtask

   task automatic add_type(input logic [7:0] dtype, input logic [15:0] clen);
      frame_body.push_back(dtype);
      frame_body.push_back(clen[15:8]);
      frame_body.push_back(clen[7:0]);
   endtask

   task automatic add_number(input logic [7:0] sign, input logic [31:0] mag);
      frame_body.push_back(sign);
      frame_body.push_back(mag[31:24]);
      frame_body.push_back(mag[23:16]);
      frame_body.push_back(mag[15:8]);
      frame_body.push_back(mag[7:0]);
   endtask

   // Announce a length (the body's own when negative) and send at most that much of the body.
   task automatic send_frame(input int declared);
      if (declared < 0) declared = frame_body.size();
      send_prefix(declared);
      for (int i = 0; i < declared && i < frame_body.size(); i++) begin
         stream_backlog.push_back(frame_body[i]);
         bytes_planned++;
      end
   endtask

   // Mostly well-formed packets with random content; some noise prefixes,
   // cut payloads and oversize lengths mixed in.
   task automatic queue_random_packet();
      int unsigned pick;
      int          declared;
      int          nbytes;
      logic [7:0]  tlen;
      logic [7:0]  dtype;
      logic [7:0]  lead;
      logic [15:0] clen;
      logic [15:0] min_bytes;
      logic [23:0] tail;
      pick = $urandom_range(99);
      if (pick < 6) begin
         // non-zero top byte keeps the prefix above any limit
         lead = 8'($urandom_range(255, 1));
         tail = 24'($urandom);
         send_prefix({lead, tail});
      end else if (pick < 9) begin
         send_prefix(32'd0);
      end else begin
         tlen = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(4));
         open_frame($urandom, 16'($urandom), tlen);
         case ($urandom_range(9))
            0, 1:    dtype = TYPE_INT;
            2, 3:    dtype = TYPE_SREAL;
            4, 5:    dtype = TYPE_FLOAT;
            6, 7:    dtype = TYPE_STRING;
            8:       dtype = 8'($urandom_range(255, 4));
            default: dtype = 8'($urandom);
         endcase
         case (dtype)
            TYPE_INT:   min_bytes = INT_MIN_BYTES;
            TYPE_SREAL: min_bytes = SREAL_MIN_BYTES;
            TYPE_FLOAT: min_bytes = FLOAT_MIN_BYTES;
            default:    min_bytes = 16'd0;
         endcase
         if ($urandom_range(19) == 0) clen = 16'($urandom);
         else if ($urandom_range(6) == 0) clen = 16'($urandom_range(5));
         else clen = min_bytes + 16'($urandom_range(2));
         add_type(dtype, clen);
         // an oversize content length gets only a few bytes behind it
         nbytes = (clen > 16'd8) ? int'($urandom_range(3)) : int'(clen);
         if (nbytes > 0 && (dtype == TYPE_INT || dtype == TYPE_FLOAT)) begin
            pick = $urandom_range(9);
            if (pick < 4) lead = 8'd0;
            else if (pick < 8) lead = 8'd1;
            else lead = 8'($urandom);
            frame_body.push_back(lead);
            add_random(nbytes - 1);
         end else begin
            add_random(nbytes);
         end
         if ($urandom_range(3) == 0) add_random(int'($urandom_range(3, 1)));
         declared = frame_body.size();
         if ($urandom_range(4) == 0 || tlen > 8'd8)
            declared = int'($urandom_range((tlen > 8'd8) ? 20 : frame_body.size() - 1, 1));
         if (declared > max_len && max_len != 0 && $urandom_range(7) != 0)
            declared = int'($urandom_range(max_len, 1));
         send_frame(declared);
      end
   endtask

   task automatic queue_random_stream(input int unsigned count);
      int unsigned target;
      target = bytes_planned + count;
      while (bytes_planned < target) queue_random_packet();
   endtask

   task automatic wait_for_drain();
      while (stream_backlog.size() != 0 || expected_records.size() != 0)
         @(posedge clock);
   endtask

   // Write the limit only once the block has gone quiet.
   task automatic program_limit(input logic [16:0] value);
      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en           <= 1'b1;
      csr_max_payload_len <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      max_len = value;
   endtask

   // ------------------------------------------------------------------
   // Sequence of the run
   // ------------------------------------------------------------------
   initial begin
      max_len  = MAX_LEN_RESET;
      ph       = PH_LEN;
      pay_left = '0;
      clear_packet();

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // sender idles a little, receiver a lot
      send_idle_pct = 38;
      recv_idle_pct = 68;

      // extremes of the header and an int with the largest magnitude
      open_frame(32'hFFFF_FFFF, 16'hFFFF, 8'd0);
      add_type(TYPE_INT, INT_MIN_BYTES);
      add_number(8'd0, 32'hFFFF_FFFF);
      send_frame(-1);
      // negative zero, then a longer int with trailing bytes
      open_frame(32'd0, 16'd0, 8'd2);
      add_type(TYPE_INT, INT_MIN_BYTES);
      add_number(8'd1, 32'd0);
      send_frame(-1);
      open_frame($urandom, 16'($urandom), 8'd1);
      add_type(TYPE_INT, 16'd6);
      add_number(8'd1, 32'h8000_0001);
      add_random(3);
      send_frame(-1);
      // short real, float, negative float with extra content
      open_frame($urandom, 16'($urandom), 8'd3);
      add_type(TYPE_SREAL, SREAL_MIN_BYTES);
      frame_body.push_back(8'hFF);
      frame_body.push_back(8'hFF);
      add_random(2);
      send_frame(-1);
      open_frame($urandom, 16'($urandom), 8'd0);
      add_type(TYPE_FLOAT, FLOAT_MIN_BYTES);
      add_number(8'd0, 32'd12345);
      frame_body.push_back(8'hFF);
      send_frame(-1);
      open_frame($urandom, 16'($urandom), 8'd1);
      add_type(TYPE_FLOAT, 16'd8);
      add_number(8'd1, 32'hFFFF_FFFF);
      frame_body.push_back(8'd3);
      add_random(2);
      send_frame(-1);
      // strings, the empty one with trailing bytes
      open_frame($urandom, 16'($urandom), 8'd2);
      add_type(TYPE_STRING, 16'd4);
      add_random(4);
      send_frame(-1);
      open_frame($urandom, 16'($urandom), 8'd0);
      add_type(TYPE_STRING, 16'd0);
      add_random(3);
      send_frame(-1);
      // unknown types still pass their content
      open_frame($urandom, 16'($urandom), 8'd1);
      add_type(8'd4, 16'd3);
      add_random(3);
      send_frame(-1);
      open_frame($urandom, 16'($urandom), 8'd0);
      add_type(8'hFF, 16'd1);
      add_random(1);
      send_frame(-1);
      // bad sign bytes
      open_frame($urandom, 16'($urandom), 8'd0);
      add_type(TYPE_INT, INT_MIN_BYTES);
      add_number(8'd2, $urandom);
      send_frame(-1);
      open_frame($urandom, 16'($urandom), 8'd0);
      add_type(TYPE_FLOAT, FLOAT_MIN_BYTES);
      add_number(8'hFF, $urandom);
      add_random(1);
      send_frame(-1);
      // content one byte short for each numeric type, and none at all
      open_frame($urandom, 16'($urandom), 8'd0);
      add_type(TYPE_INT, 16'd4);
      add_random(4);
      send_frame(-1);
      open_frame($urandom, 16'($urandom), 8'd0);
      add_type(TYPE_SREAL, 16'd1);
      add_random(1);
      send_frame(-1);
      open_frame($urandom, 16'($urandom), 8'd0);
      add_type(TYPE_FLOAT, 16'd5);
      add_number(8'd0, $urandom);
      send_frame(-1);
      open_frame($urandom, 16'($urandom), 8'd0);
      add_type(TYPE_INT, 16'd0);
      send_frame(-1);
      // cut the payload at points within the header; the last cut lands inside
      // the content length field, so every cut leaves the header incomplete
      open_frame(32'h0102_0304, 16'h0506, 8'd0);
      add_type(TYPE_INT, INT_MIN_BYTES);
      add_number(8'd0, 32'd99);
      send_frame(2);
      send_frame(5);
      send_frame(6);
      send_frame(7);
      send_frame(8);
      send_frame(9);
      // topic overrun, content overrun at the widest length
      open_frame($urandom, 16'($urandom), 8'd10);
      add_type(TYPE_STRING, 16'd1);
      add_random(1);
      send_frame(9);
      open_frame($urandom, 16'($urandom), 8'd0);
      add_type(TYPE_STRING, 16'hFFFF);
      add_random(3);
      send_frame(-1);
      // bad length prefixes: zero, all ones, one above the limit
      send_prefix(32'd0);
      send_prefix(32'hFFFF_FFFF);
      send_prefix({15'd0, MAX_LEN_RESET} + 32'd1);
      // the longest topic overruns a short payload
      open_frame($urandom, 16'($urandom), 8'd255);
      add_type(TYPE_STRING, 16'd1);
      add_random(1);
      send_frame(7);

      // a packet exactly at the limit passes, one byte more does not
      program_limit(17'd20);
      open_frame($urandom, 16'($urandom), 8'd2);
      add_type(TYPE_INT, 16'd8);
      add_number(8'd1, $urandom);
      add_random(3);
      send_frame(-1);
      send_prefix(32'd21);

      // zero limit: every prefix is refused
      program_limit(17'd0);
      send_prefix(32'd1);
      send_prefix(32'd0);
      send_prefix({15'd0, LIMIT_MAX});

      // a limit of one leaves only the first address byte
      program_limit(17'd1);
      open_frame($urandom, 16'($urandom), 8'd0);
      send_frame(1);
      send_frame(1);
      send_prefix(32'd2);

      program_limit(LIMIT_MAX);
      send_prefix({15'd0, LIMIT_MAX} + 32'd1);
      queue_random_stream(RANDOM_BYTES);

      // receiver idles a little, sender a lot, under a tight limit
      program_limit(17'($urandom_range(40, 9)));
      send_idle_pct = 68;
      recv_idle_pct = 38;
      queue_random_stream(RANDOM_BYTES);

      // no idling on either side, back at the reset limit
      program_limit(MAX_LEN_RESET);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      queue_random_stream(RANDOM_BYTES);

      // drain, then allow time for any stray result to show up
      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("length_prefixed_message_deframer_core test passed");
      end else begin
         $display("length_prefixed_message_deframer_core test failed");
      end
      $finish;
   end

   // Watchdog for a hung handshake or results that never come.
   initial begin
      #TIMEOUT_NS;
      $display("length_prefixed_message_deframer_core test failed");
      $finish;
   end

endmodule
